// ===== sv/cnmf_pkg.sv =====
package cnmf_pkg;

  // Pixel and arithmetic widths
  localparam int PIX_W = 8;
  localparam int SUM_W = 10;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_W_BITS = 11;
  localparam int CFG_H_BITS = 13;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  // Keep limits: mode 0 needs one full neighbor, mode 1 needs all four
  localparam logic [SUM_W-1:0] LIMIT_LOW  = 10'd255;
  localparam logic [SUM_W-1:0] LIMIT_HIGH = 10'd1020;

  // Command queue between front and back
  localparam int CNMF_QDEPTH = 4;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] pixel;
  } cnmf_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last_in_frame;
  } cnmf_out_t;

  // Border handling for one output pixel
  typedef struct packed {
    logic up_ok;
    logic dn_ok;
    logic lf_ok;
    logic rt_ok;
    logic last;
  } cnmf_flags_t;

endpackage

// ===== sv/cnmf_pix_ram.sv =====
module cnmf_pix_ram #(
  parameter int AW = 12
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [cnmf_pkg::PIX_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr0,
  input  logic [AW-1:0]             rd_addr1,
  output logic [cnmf_pkg::PIX_W-1:0] rd_data0,
  output logic [cnmf_pkg::PIX_W-1:0] rd_data1
);
  import cnmf_pkg::*;

  logic [PIX_W-1:0] pix_mem [2**AW];
  logic [PIX_W-1:0] rd0_r;
  logic [PIX_W-1:0] rd1_r;

  // Single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pix_mem[wr_addr] <= wr_data;
    end
  end

  // Two registered read ports, held while the reader stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd0_r <= pix_mem[rd_addr0];
      rd1_r <= pix_mem[rd_addr1];
    end
  end

  assign rd_data0 = rd0_r;
  assign rd_data1 = rd1_r;

endmodule

// ===== sv/cnmf_cmd_fifo.sv =====
module cnmf_cmd_fifo #(
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          not_empty,
  output logic          full
);
  import cnmf_pkg::*;

  localparam int PW = $clog2(CNMF_QDEPTH);

  logic [DW-1:0] slot_r [CNMF_QDEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  // Pointer and fill count update
  always_comb begin
    wp_nxt  = push ? wp_r + PW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (PW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  assign pop_data  = slot_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (PW+1)'(CNMF_QDEPTH));

  // The front must never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < (PW+1)'(CNMF_QDEPTH)))
    else $error("command queue overflow");

endmodule

// ===== sv/cnmf_front.sv =====
module cnmf_front #(
  parameter int WW = 11,
  parameter int HW = 13,
  parameter int CW = 23,
  parameter int AW = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cnmf_pkg::cnmf_in_t         in_data,
  input  logic                       restart,
  input  logic [WW-1:0]              w_i,
  input  logic [HW-1:0]              h_i,
  input  logic [CW-1:0]              total_i,
  input  logic                       fifo_full,
  output logic                       push,
  output logic [AW-1:0]              cmd_addr,
  output cnmf_pkg::cnmf_flags_t      cmd_flags,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [cnmf_pkg::PIX_W-1:0] wr_data
);
  import cnmf_pkg::*;

  logic [CW-1:0] in_cnt_r, in_cnt_nxt;
  logic [CW-1:0] out_cnt_r, out_cnt_nxt;
  logic [WW-1:0] x_r, x_nxt;
  logic [HW-1:0] y_r, y_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;

  logic          accept;
  logic          wr;
  logic          emit;
  logic          x_end;
  logic          y_end;
  logic          last;
  logic [CW-1:0] in_new;
  logic [CW:0]   thr;

  // Classify the transfer: store pixel, and decide whether the next output is ready
  always_comb begin
    accept = in_valid & in_ready;
    wr     = accept & ~in_data.action & (in_cnt_r < total_i);
    in_new = in_cnt_r + CW'(wr);
    thr    = (CW+1)'(out_cnt_r) + (CW+1)'(w_i) + (CW+1)'(1);
    emit   = accept & (out_cnt_r < total_i) &
             ((in_new >= total_i) | ((CW+1)'(in_new) >= thr));
    x_end  = ((x_r + WW'(1)) == w_i);
    y_end  = ((y_r + HW'(1)) == h_i);
    last   = ((out_cnt_r + CW'(1)) == total_i);
  end

  // Border flags for output pixel out_cnt
  always_comb begin
    cmd_flags.up_ok = (y_r != '0);
    cmd_flags.dn_ok = ~y_end;
    cmd_flags.lf_ok = (x_r != '0);
    cmd_flags.rt_ok = ~x_end;
    cmd_flags.last  = last;
  end

  // Counter and pointer update
  always_comb begin
    in_cnt_nxt  = in_cnt_r;
    out_cnt_nxt = out_cnt_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    if (restart) begin
      in_cnt_nxt  = '0;
      out_cnt_nxt = '0;
      x_nxt       = '0;
      y_nxt       = '0;
      rp_nxt      = wp_r;
    end else begin
      if (wr) begin
        in_cnt_nxt = in_new;
        wp_nxt     = wp_r + AW'(1);
      end
      if (emit) begin
        rp_nxt = rp_r + AW'(1);
        if (last) begin
          in_cnt_nxt  = '0;
          out_cnt_nxt = '0;
          x_nxt       = '0;
          y_nxt       = '0;
        end else begin
          out_cnt_nxt = out_cnt_r + CW'(1);
          if (x_end) begin
            x_nxt = '0;
            y_nxt = y_r + HW'(1);
          end else begin
            x_nxt = x_r + WW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      x_r       <= '0;
      y_r       <= '0;
      wp_r      <= '0;
      rp_r      <= '0;
    end else begin
      in_cnt_r  <= in_cnt_nxt;
      out_cnt_r <= out_cnt_nxt;
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
    end
  end

  assign in_ready = ~fifo_full;
  assign push     = emit;
  assign cmd_addr = rp_r;
  assign wr_en    = wr;
  assign wr_addr  = wp_r;
  assign wr_data  = in_data.pixel;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_cnt_r < total_i) && (in_cnt_r <= total_i))
    else $error("frame counters out of range");

  // Pending pixels never exceed one row, which bounds the store depth
  a_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    (CW+1)'(in_cnt_r) <= (CW+1)'(out_cnt_r) + (CW+1)'(w_i))
    else $error("input ran more than a row ahead");

  // Store pointers track the frame counters
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) == AW'(in_cnt_r - out_cnt_r))
    else $error("store pointers out of step with counters");

endmodule

// ===== sv/cnmf_back.sv =====
module cnmf_back #(
  parameter int WW = 11,
  parameter int AW = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       mode_i,
  input  logic [WW-1:0]              w_i,
  input  logic                       cmd_valid,
  input  logic [AW-1:0]              cmd_addr,
  input  cnmf_pkg::cnmf_flags_t      cmd_flags,
  output logic                       pop,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [cnmf_pkg::PIX_W-1:0] wr_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cnmf_pkg::cnmf_out_t        out_data
);
  import cnmf_pkg::*;

  logic [AW-1:0]    w_a;
  logic [PIX_W-1:0] d_up, d_dn, d_c, d_rt;
  logic [PIX_W-1:0] up_v, dn_v, lf_v, rt_v;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] limit;
  logic [PIX_W-1:0] pix_v;
  logic             b_adv;

  logic             b_valid_r, b_valid_nxt;
  cnmf_flags_t      b_flags_r;
  logic [PIX_W-1:0] lf_r;
  logic             out_valid_r, out_valid_nxt;
  cnmf_out_t        out_data_r;

  assign w_a = AW'(w_i);

  // Vertical neighbors: one store copy, two ports
  cnmf_pix_ram #(.AW(AW)) u_ram_vert (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (pop),
    .rd_addr0 (cmd_addr - w_a),
    .rd_addr1 (cmd_addr + w_a),
    .rd_data0 (d_up),
    .rd_data1 (d_dn)
  );

  // Center and right neighbor: second copy
  cnmf_pix_ram #(.AW(AW)) u_ram_horz (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (pop),
    .rd_addr0 (cmd_addr),
    .rd_addr1 (cmd_addr + AW'(1)),
    .rd_data0 (d_c),
    .rd_data1 (d_rt)
  );

  // Stage handshake
  always_comb begin
    b_adv = b_valid_r & (~out_valid_r | out_ready);
    pop   = cmd_valid & (~b_valid_r | b_adv);
    b_valid_nxt = pop ? 1'b1 : (b_adv ? 1'b0 : b_valid_r);
    out_valid_nxt = b_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // Border clamp, neighbor sum and keep decision; left is the previous center
  always_comb begin
    up_v  = b_flags_r.up_ok ? d_up : d_c;
    dn_v  = b_flags_r.dn_ok ? d_dn : d_c;
    lf_v  = b_flags_r.lf_ok ? lf_r : d_c;
    rt_v  = b_flags_r.rt_ok ? d_rt : d_c;
    sum   = SUM_W'(up_v) + SUM_W'(dn_v) + SUM_W'(lf_v) + SUM_W'(rt_v);
    limit = mode_i ? LIMIT_HIGH : LIMIT_LOW;
    pix_v = (sum < limit) ? '0 : d_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      b_flags_r <= cmd_flags;
    end
    if (b_adv) begin
      lf_r                     <= d_c;
      out_data_r.pixel_out     <= pix_v;
      out_data_r.last_in_frame <= b_flags_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A stalled read stage keeps its command
  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_adv) |=> (b_valid_r && $stable(b_flags_r)))
    else $error("read stage lost its command while stalled");

endmodule

// ===== sv/cross_neighbor_morphology_filter_unit.sv =====
// Latency: a result passes the command queue, the read stage and the output register after
//   the transfer that completes its window (pixel k+W, or a flush tick once the frame is in).
// Throughput: one transfer per cycle, in and out, when neither side stalls; set by the four
//   line store reads per result (two dual-read copies) and the single sum-and-compare stage.
// Reset (synchronous, rst_n low): counters, queue and output stage clear; mode 0,
//   width 1024, height 1024 (clamped to the limits). The line store is not cleared.
module cross_neighbor_morphology_filter_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cnmf_pkg::cnmf_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cnmf_pkg::cnmf_out_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cnmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cnmf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cnmf_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int AW = $clog2(2 * MAX_WIDTH + 2 * CNMF_QDEPTH + 2);
  localparam int FW = $bits(cnmf_flags_t);
  localparam int DW = AW + FW;
  localparam int RST_W = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam int RST_H = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;
  localparam int RST_TOTAL = RST_W * RST_H;

  logic             mode_r, mode_nxt;
  logic [WW-1:0]    weff_r, weff_nxt;
  logic [HW-1:0]    heff_r, heff_nxt;
  logic [CW-1:0]    total_r, total_nxt;
  logic [WW+HW-1:0] prod;
  logic [WW-1:0]    w_clamp;
  logic [HW-1:0]    h_clamp;
  logic             cfg_wr;
  logic             restart;

  logic              fifo_full;
  logic              fifo_ne;
  logic              push;
  logic              pop;
  logic [AW-1:0]     f_addr;
  cnmf_flags_t       f_flags;
  logic [DW-1:0]     q_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [PIX_W-1:0]  wr_data;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  // Clamp written sizes to 1..MAX
  always_comb begin
    int w_int;
    int h_int;
    w_int = int'(cfg_data[CFG_W_BITS-1:0]);
    h_int = int'(cfg_data[CFG_H_BITS-1:0]);
    if (w_int == 0) begin
      w_int = 1;
    end else if (w_int > MAX_WIDTH) begin
      w_int = MAX_WIDTH;
    end
    if (h_int == 0) begin
      h_int = 1;
    end else if (h_int > MAX_HEIGHT) begin
      h_int = MAX_HEIGHT;
    end
    w_clamp = WW'(w_int);
    h_clamp = HW'(h_int);
  end

  // Register decode; pixel count is refreshed with the size
  always_comb begin
    mode_nxt = mode_r;
    weff_nxt = weff_r;
    heff_nxt = heff_r;
    restart  = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_index)
        REG_MODE: begin
          mode_nxt = cfg_data[0];
        end
        REG_WIDTH: begin
          weff_nxt = w_clamp;
          restart  = 1'b1;
        end
        REG_HEIGHT: begin
          heff_nxt = h_clamp;
          restart  = 1'b1;
        end
        default: begin
        end
      endcase
    end
    prod      = weff_nxt * heff_nxt;
    total_nxt = CW'(prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      weff_r  <= WW'(RST_W);
      heff_r  <= HW'(RST_H);
      total_r <= CW'(RST_TOTAL);
    end else begin
      mode_r  <= mode_nxt;
      weff_r  <= weff_nxt;
      heff_r  <= heff_nxt;
      total_r <= total_nxt;
    end
  end

  cnmf_front #(.WW(WW), .HW(HW), .CW(CW), .AW(AW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .restart   (restart),
    .w_i       (weff_r),
    .h_i       (heff_r),
    .total_i   (total_r),
    .fifo_full (fifo_full),
    .push      (push),
    .cmd_addr  (f_addr),
    .cmd_flags (f_flags),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  cnmf_cmd_fifo #(.DW(DW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_addr, f_flags}),
    .pop       (pop),
    .pop_data  (q_data),
    .not_empty (fifo_ne),
    .full      (fifo_full)
  );

  cnmf_back #(.WW(WW), .AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode_i    (mode_r),
    .w_i       (weff_r),
    .cmd_valid (fifo_ne),
    .cmd_addr  (q_data[DW-1 -: AW]),
    .cmd_flags (cnmf_flags_t'(q_data[FW-1:0])),
    .pop       (pop),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
